// File: src/edge_prediction_filter_core_macros.svh
// assertion macros for the edge prediction filter checker
// depends on nothing; the including module must provide i_clk and i_rst_n
`ifndef EDGE_PREDICTION_FILTER_CORE_MACROS_SVH
`define EDGE_PREDICTION_FILTER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define EPF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define EPF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define EPF_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/epf_pkg.sv
// shared types, constants and helper functions for the edge prediction filter
// no dependencies
`default_nettype none

package epf_pkg;

    localparam int PIX_W           = 12;
    localparam int LINE_W          = 6 * PIX_W;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 15;
    localparam int DEPTH_W         = 4;
    localparam int QT_W            = 12;
    localparam int ST_W            = 15;
    localparam int MULT_W          = 8;
    localparam int LIM_W           = 15;
    localparam int LIM_MAX         = 32767;
    localparam int QPROD_W         = QT_W + MULT_W;
    localparam int DIFF2_W         = 15;
    localparam int DELTA_W         = 18;
    localparam int CLAMP_W         = 16;
    localparam int SCALED_W        = 24;
    localparam int PROD_W          = 26;
    localparam int OFS_W           = 16;
    localparam int SUM_W           = 18;
    localparam int DEPTH_MIN       = 8;
    localparam int DEPTH_MAX       = 12;
    localparam int ROUND_SHIFT_DEF = 7;

    localparam logic [DEPTH_W-1:0] BIT_DEPTH_RST = 4'd10;
    localparam logic [QT_W-1:0]    CLAMP_THR_RST = '0;
    localparam logic [ST_W-1:0]    ACT_THR_RST   = '0;
    localparam logic [MULT_W-1:0]  Q_MULT_RST    = 8'd1;
    localparam logic [MULT_W-1:0]  W_MULT_RST    = '0;

    localparam logic signed [PROD_W-1:0] OFS_HI = 26'sd32767;
    localparam logic signed [PROD_W-1:0] OFS_LO = -26'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_DEPTH = 3'd0,
        CFG_CLAMP_THR = 3'd1,
        CFG_ACT_THR   = 3'd2,
        CFG_Q_MULT    = 3'd3,
        CFG_W_MULT    = 3'd4
    } t_cfg_idx;

    // near_p sits in the lowest bits so the struct maps straight onto tdata
    typedef struct packed {
        logic [PIX_W-1:0] far_m;
        logic [PIX_W-1:0] mid_m;
        logic [PIX_W-1:0] near_m;
        logic [PIX_W-1:0] far_p;
        logic [PIX_W-1:0] mid_p;
        logic [PIX_W-1:0] near_p;
    } t_line;

    typedef struct packed {
        logic [DEPTH_W-1:0] bit_depth;
        logic [QT_W-1:0]    clamp_thr;
        logic [ST_W-1:0]    act_thr;
        logic [MULT_W-1:0]  q_mult;
        logic [MULT_W-1:0]  w_mult;
    } t_cfg;

    typedef struct packed {
        t_line              line;
        logic               filter_on;
        logic [DELTA_W-1:0] delta;
        logic [LIM_W-1:0]   lim;
    } t_s1;

    typedef struct packed {
        t_line               line;
        logic                filter_on;
        logic [SCALED_W-1:0] scaled;
    } t_s2;

    typedef struct packed {
        t_line            line;
        logic             filter_on;
        logic [OFS_W-1:0] ofs_near;
        logic [OFS_W-1:0] ofs_mid;
        logic [OFS_W-1:0] ofs_far;
    } t_s3;

    // |a - 2*b + c|
    function automatic logic [DIFF2_W-1:0] act_abs(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c
    );
        logic signed [DIFF2_W-1:0] s;
        s = $signed({3'b000, a}) - $signed({2'b00, b, 1'b0}) + $signed({3'b000, c});
        act_abs = s[DIFF2_W-1] ? $unsigned(-s) : $unsigned(s);
    endfunction

    // saturate to signed 16 bits
    function automatic logic [OFS_W-1:0] sat_ofs(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v;
        if (v > OFS_HI) t = OFS_HI;
        if (v < OFS_LO) t = OFS_LO;
        sat_ofs = t[OFS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/edge_prediction_filter_core.sv
// top level of the edge prediction filter: config registers and four-stage pipeline
// depends on epf_pkg, epf_prep, epf_scale, epf_offset, epf_apply
`default_nettype none

// Filters one six-pixel line across a block edge per beat. The datapath is a
// four-stage pipeline (activity test and delta, clamp and weight, offsets,
// apply and clip); each stage holds its own valid bit and the ready of a stage
// is "empty or the next stage moves", so a new line is taken every cycle while
// the output side keeps up, and bubbles inside the pipe are squeezed out while
// the output side stalls. Sustained rate is one line per cycle while the output
// side keeps up. Configuration registers are written through a plain write
// port and must only change while the pipeline is empty. A line with filter_on
// low leaves unchanged and unclipped.

module edge_prediction_filter_core import epf_pkg::*; #(
    parameter int ROUND_SHIFT = ROUND_SHIFT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // near_p, mid_p, far_p, near_m, mid_m, far_m (12 bits each, lowest first)
    input  wire logic [LINE_W-1:0]     s_axis_tdata,
    // filter_on
    input  wire logic [0:0]            s_axis_tuser,
    // output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_near_p, out_mid_p, out_far_p, out_near_m, out_mid_m, out_far_m (12 bits each)
    output logic [LINE_W-1:0]          m_axis_tdata,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg  r_cfg;
    t_line in_line;
    t_line out_line;

    // stage handshakes
    logic  s1_valid, s1_ready;
    logic  s2_valid, s2_ready;
    logic  s3_valid, s3_ready;
    logic  s4_ready;
    t_s1   s1;
    t_s2   s2;
    t_s3   s3;

    // configuration registers, writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_depth <= BIT_DEPTH_RST;
            r_cfg.clamp_thr <= CLAMP_THR_RST;
            r_cfg.act_thr   <= ACT_THR_RST;
            r_cfg.q_mult    <= Q_MULT_RST;
            r_cfg.w_mult    <= W_MULT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BIT_DEPTH: r_cfg.bit_depth <= i_cfg_wdata[DEPTH_W-1:0];
                CFG_CLAMP_THR: r_cfg.clamp_thr <= i_cfg_wdata[QT_W-1:0];
                CFG_ACT_THR:   r_cfg.act_thr   <= i_cfg_wdata[ST_W-1:0];
                CFG_Q_MULT:    r_cfg.q_mult    <= i_cfg_wdata[MULT_W-1:0];
                CFG_W_MULT:    r_cfg.w_mult    <= i_cfg_wdata[MULT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // tdata layout matches the line struct bit for bit
    assign in_line      = t_line'(s_axis_tdata);
    assign m_axis_tdata = LINE_W'(out_line);

    // stage 1: activity test, raw delta, clamp limit
    epf_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_line      (in_line),
        .i_filter_on (s_axis_tuser[0]),
        .i_cfg       (r_cfg),
        .o_valid     (s1_valid),
        .i_ready     (s1_ready),
        .o_s1        (s1)
    );

    // stage 2: clamp and weight
    epf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_s1    (s1),
        .i_cfg   (r_cfg),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_s2    (s2)
    );

    // stage 3: rounded offsets for the near, mid and far pixels
    epf_offset #(
        .ROUND_SHIFT (ROUND_SHIFT)
    ) u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_s2    (s2),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_s3    (s3)
    );

    // stage 4: apply, clip, and hold the output beat
    epf_apply u_apply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_s3    (s3),
        .i_cfg   (r_cfg),
        .o_valid (m_axis_tvalid),
        .i_ready (s4_ready),
        .o_line  (out_line)
    );

    assign s4_ready = m_axis_tready;

endmodule

`default_nettype wire

// File: src/epf_prep.sv
// stage 1: raw delta, side activity test and clamp limit
// depends on epf_pkg
`default_nettype none

module epf_prep import epf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_line i_line,
    input  wire logic  i_filter_on,
    input  wire t_cfg  i_cfg,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_s1        o_s1
);

    logic                      r_valid;
    t_s1                       r_s1;
    t_s1                       n_s1;
    logic signed [PIX_W:0]     dn;
    logic signed [PIX_W:0]     dm;
    logic signed [CLAMP_W-1:0] base;
    logic                      smooth;
    logic [QPROD_W-1:0]        qprod;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_s1    = r_s1;

    always_comb begin
        dn    = $signed({1'b0, i_line.near_p}) - $signed({1'b0, i_line.near_m});
        dm    = $signed({1'b0, i_line.mid_p}) - $signed({1'b0, i_line.mid_m});
        base  = (CLAMP_W'(dn) <<< 1) + CLAMP_W'(dn) - CLAMP_W'(dm);
        smooth = (act_abs(i_line.far_m, i_line.mid_m, i_line.near_m) <= i_cfg.act_thr)
              && (act_abs(i_line.near_p, i_line.mid_p, i_line.far_p) <= i_cfg.act_thr);
        qprod = QPROD_W'(i_cfg.clamp_thr) * QPROD_W'(i_cfg.q_mult);

        n_s1.line      = i_line;
        n_s1.filter_on = i_filter_on;
        n_s1.delta     = smooth ? {base, 2'b00} : '0;
        n_s1.lim       = (qprod > QPROD_W'(LIM_MAX)) ? LIM_W'(LIM_MAX) : qprod[LIM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1 <= n_s1;
        end
    end

endmodule

`default_nettype wire

// File: src/epf_scale.sv
// stage 2: clamp the delta to the limit and weight it
// depends on epf_pkg
`default_nettype none

module epf_scale import epf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_s1   i_s1,
    input  wire t_cfg  i_cfg,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_s2        o_s2
);

    logic                        r_valid;
    t_s2                         r_s2;
    t_s2                         n_s2;
    logic signed [DELTA_W-1:0]   dl;
    logic signed [DELTA_W-1:0]   lim_s;
    logic signed [DELTA_W-1:0]   cl;
    logic signed [CLAMP_W-1:0]   cl16;
    logic signed [SCALED_W:0]    prod;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_s2    = r_s2;

    always_comb begin
        dl    = $signed(i_s1.delta);
        lim_s = $signed({3'b000, i_s1.lim});
        cl    = dl;
        if (dl > lim_s)  cl = lim_s;
        if (dl < -lim_s) cl = -lim_s;
        cl16  = cl[CLAMP_W-1:0];
        prod  = (SCALED_W+1)'(cl16) * (SCALED_W+1)'($signed({1'b0, i_cfg.w_mult}));

        n_s2.line      = i_s1.line;
        n_s2.filter_on = i_s1.filter_on;
        n_s2.scaled    = prod[SCALED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2 <= n_s2;
        end
    end

endmodule

`default_nettype wire

// File: src/epf_offset.sv
// stage 3: three rounded, shifted and saturated offsets
// depends on epf_pkg
`default_nettype none

module epf_offset import epf_pkg::*; #(
    parameter int ROUND_SHIFT = ROUND_SHIFT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_s2   i_s2,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_s3        o_s3
);

    localparam logic signed [PROD_W-1:0] RND = PROD_W'((1 << ROUND_SHIFT) >> 1);

    logic                     r_valid;
    t_s3                      r_s3;
    t_s3                      n_s3;
    logic signed [PROD_W-1:0] k1;
    logic signed [PROD_W-1:0] k2;
    logic signed [PROD_W-1:0] k3;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_s3    = r_s3;

    always_comb begin
        k1 = PROD_W'($signed(i_s2.scaled));
        k2 = k1 <<< 1;
        k3 = k2 + k1;

        n_s3.line      = i_s2.line;
        n_s3.filter_on = i_s2.filter_on;
        n_s3.ofs_near  = sat_ofs((k3 + RND) >>> ROUND_SHIFT);
        n_s3.ofs_mid   = sat_ofs((k2 + RND) >>> ROUND_SHIFT);
        n_s3.ofs_far   = sat_ofs((k1 + RND) >>> ROUND_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s3 <= n_s3;
        end
    end

endmodule

`default_nettype wire

// File: src/epf_apply.sv
// stage 4: apply offsets, clip to bit depth, output register
// depends on epf_pkg
`default_nettype none

module epf_apply import epf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_s3   i_s3,
    input  wire t_cfg  i_cfg,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_line      o_line
);

    logic               r_valid;
    t_line              r_line;
    t_line              n_line;
    logic [DEPTH_W-1:0] dep;
    logic [PIX_W-1:0]   maxv;
    logic [PIX_W:0]     full;

    // pix + ofs or pix - ofs, clipped to 0..maxv
    function automatic logic [PIX_W-1:0] clip_pel(
        input logic [PIX_W-1:0] pix,
        input logic [OFS_W-1:0] ofs,
        input logic             sub,
        input logic [PIX_W-1:0] mx
    );
        logic signed [SUM_W-1:0] p;
        logic signed [SUM_W-1:0] o;
        logic signed [SUM_W-1:0] s;
        logic [PIX_W-1:0]        r;
        p = $signed({{(SUM_W-PIX_W){1'b0}}, pix});
        o = $signed({{(SUM_W-OFS_W){ofs[OFS_W-1]}}, ofs});
        s = sub ? (p - o) : (p + o);
        r = s[PIX_W-1:0];
        if (s < 0) r = '0;
        else if (s > $signed({{(SUM_W-PIX_W){1'b0}}, mx})) r = mx;
        clip_pel = r;
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_line  = r_line;

    always_comb begin
        dep = i_cfg.bit_depth;
        if (i_cfg.bit_depth < DEPTH_W'(DEPTH_MIN)) dep = DEPTH_W'(DEPTH_MIN);
        if (i_cfg.bit_depth > DEPTH_W'(DEPTH_MAX)) dep = DEPTH_W'(DEPTH_MAX);
        full = ((PIX_W+1)'(1) << dep) - (PIX_W+1)'(1);
        maxv = full[PIX_W-1:0];

        if (i_s3.filter_on) begin
            n_line.near_p = clip_pel(i_s3.line.near_p, i_s3.ofs_near, 1'b1, maxv);
            n_line.mid_p  = clip_pel(i_s3.line.mid_p,  i_s3.ofs_mid,  1'b1, maxv);
            n_line.far_p  = clip_pel(i_s3.line.far_p,  i_s3.ofs_far,  1'b1, maxv);
            n_line.near_m = clip_pel(i_s3.line.near_m, i_s3.ofs_near, 1'b0, maxv);
            n_line.mid_m  = clip_pel(i_s3.line.mid_m,  i_s3.ofs_mid,  1'b0, maxv);
            n_line.far_m  = clip_pel(i_s3.line.far_m,  i_s3.ofs_far,  1'b0, maxv);
        end else begin
            n_line = i_s3.line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_line <= n_line;
        end
    end

endmodule

`default_nettype wire

// File: src/epf_checker.sv
// port-level checks for the edge prediction filter, bound to the top level
// depends on epf_pkg, edge_prediction_filter_core_macros.svh
`default_nettype none

`include "edge_prediction_filter_core_macros.svh"

module epf_checker import epf_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [LINE_W-1:0] m_axis_tdata
);

    // reset empties the pipeline
    `EPF_ASSERT_RST(a_rst_empty, !i_rst_n, !m_axis_tvalid, "output valid right after reset")

    // an open output side lets the whole pipeline move
    `EPF_ASSERT_IMP(a_ready_chain, m_axis_tready, s_axis_tready, "input stalled while output open")

    // an empty output register means no stage is blocked
    `EPF_ASSERT_IMP(a_empty_ready, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

    // a stalled output beat holds
    `EPF_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled output beat changed")

endmodule

bind edge_prediction_filter_core epf_checker u_epf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
